### rtl/core/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types, widths and helpers for the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int ACC_W         = 64;
  // remainder must hold magnitude << frac bits and divisor << 32
  localparam int REM_W         = ACC_W + COORD_W;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int IDX_W         = $clog2(NUM_REGS);
  localparam int FIFO_DEPTH    = 4;
  // one stage to capture, one for the range check, one per quotient bit
  localparam int DIV_STG       = 2 + COORD_W;
  localparam int IN_W          = 3 * COORD_W;
  localparam int OUT_W         = 104;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_WZERO = 2'd2
  } status_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;
  typedef logic [2:0][COORD_W-1:0]         vec_t;
  typedef logic [3:0][ACC_W-1:0]           acc_t;

  typedef struct packed {
    logic                        vld;
    logic                        wz;
    logic [2:0]                  neg;
    logic [2:0]                  big;
    logic [2:0][REM_W-1:0]       rem;
    logic [2:0][COORD_W-1:0]     q;
    logic [ACC_W-1:0]            den;
  } dstg_t;

  function automatic logic [COORD_W-1:0] mat_elem(mat_t m, int row, int col);
    logic [REG_W-1:0] r;
    r = m[IDX_W'(row * 2 + (col >> 1))];
    return col[0] ? r[REG_W-1:COORD_W] : r[COORD_W-1:0];
  endfunction

  function automatic mat_t reset_mat(int frac_bits);
    mat_t m;
    logic [REG_W-1:0] one;
    one  = REG_W'(1) << frac_bits;
    m    = '0;
    m[0] = one;
    m[2] = one << COORD_W;
    m[5] = one;
    m[7] = one << COORD_W;
    return m;
  endfunction

endpackage

### rtl/core/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 homogeneous matrix transform of a vertex with perspective divide.
// ----------------------------------------------------------------------------
// in_tdata carries one vertex (x, y, z) in signed fixed point; out_tdata
// returns x'/w, y'/w, z'/w and a status code (ok, saturated, w zero).
// The matrix sits in eight 64-bit registers, written over cfg_* by the user
// only while no vertex is in flight (the block does not enforce this); reset
// loads the identity matrix. One beat in, one beat out, in order. A new
// vertex is taken every cycle while nothing stalls. A vertex passes the
// multiply and sum registers, the queue, the divide stages and the output
// register; the divider produces one quotient bit per stage, which sets the
// depth. When out_tready is low the divide pipe holds, the queue fills and
// then in_tready drops; nothing is lost. Reset empties every stage at once.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [hvt_pkg::IN_W-1:0]    in_tdata,   // in_x, in_y, in_z
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hvt_pkg::OUT_W-1:0]   out_tdata,  // out_x, out_y, out_z, status
  input  logic                        cfg_wr_en,
  input  logic [hvt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hvt_pkg::REG_W-1:0]   cfg_wdata
);

  hvt_pkg::mat_t cfg_r;
  hvt_pkg::acc_t f_acc, q_rd;
  logic          f_vld, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= hvt_pkg::reset_mat(FRAC_BITS);
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  hvt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vec    (in_tdata),
    .mat       (cfg_r),
    .acc_valid (f_vld),
    .acc_ready (!q_full),
    .acc_data  (f_acc)
  );

  hvt_fifo #(.DEPTH(hvt_pkg::FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_vld),
    .wdata (f_acc),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rd)
  );

  hvt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // w zero must give all-zero coordinates
  a_wzero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[97:96] == hvt_pkg::ST_WZERO |-> out_tdata[95:0] == '0)
    else $error("w zero result with nonzero coordinates");

  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[97:96] != 2'd3)
    else $error("illegal status code");

  // output is not valid when reset has just been released
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  // queue never pops while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### rtl/core/hvt_front.sv
// ----------------------------------------------------------------------------
// hvt_front
// Matrix multiply: 12 products, truncation and summing into x', y', z', w.
// ----------------------------------------------------------------------------
module hvt_front #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hvt_pkg::vec_t in_vec,
  input  hvt_pkg::mat_t mat,
  output logic          acc_valid,
  input  logic          acc_ready,
  output hvt_pkg::acc_t acc_data
);

  localparam int CW = hvt_pkg::COORD_W;
  localparam int AW = hvt_pkg::ACC_W;

  logic [2:0][3:0][AW-1:0] prod_r, prod_nxt;
  logic [3:0][AW-1:0]      s01_r, s01_nxt;
  logic [3:0][AW-1:0]      s2m_r, s2m_nxt;
  hvt_pkg::acc_t           acc_r, acc_nxt;
  logic                    v1_r, v2_r, v3_r;
  logic                    adv;

  function automatic logic [AW-1:0] smul(logic signed [CW-1:0] a,
                                         logic signed [CW-1:0] b);
    logic signed [AW-1:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [AW-1:0] floor_shift(logic [AW-1:0] v);
    logic signed [AW-1:0] s;
    s = v;
    return s >>> FRAC_BITS;
  endfunction

  assign adv       = !v3_r || acc_ready;
  assign in_ready  = adv;
  assign acc_valid = v3_r;
  assign acc_data  = acc_r;

  always_comb begin
    logic [CW-1:0] t;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[k][c] = smul(hvt_pkg::mat_elem(mat, k, c), in_vec[k]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      t          = hvt_pkg::mat_elem(mat, 3, c);
      s01_nxt[c] = floor_shift(prod_r[0][c]) + floor_shift(prod_r[1][c]);
      s2m_nxt[c] = floor_shift(prod_r[2][c]) + {{(AW-CW){t[CW-1]}}, t};
      acc_nxt[c] = s01_r[c] + s2m_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      s01_r  <= s01_nxt;
      s2m_r  <= s2m_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

### rtl/core/hvt_fifo.sv
// ----------------------------------------------------------------------------
// hvt_fifo
// Short queue between the multiply front and the divide back.
// ----------------------------------------------------------------------------
module hvt_fifo #(
  parameter int DEPTH = hvt_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hvt_pkg::acc_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output hvt_pkg::acc_t rdata
);

  localparam int AW = $clog2(DEPTH);

  hvt_pkg::acc_t mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

### rtl/core/hvt_back.sv
// ----------------------------------------------------------------------------
// hvt_back
// Perspective divide: pipelined restoring divider, one quotient bit a stage,
// three lanes, then saturation and status into the output register.
// ----------------------------------------------------------------------------
module hvt_back #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  hvt_pkg::acc_t               q_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [hvt_pkg::OUT_W-1:0]   out_tdata
);

  localparam int CW = hvt_pkg::COORD_W;
  localparam int AW = hvt_pkg::ACC_W;
  localparam int RW = hvt_pkg::REM_W;
  localparam int NS = hvt_pkg::DIV_STG;

  hvt_pkg::dstg_t [NS-1:0] stg_r, stg_nxt;
  logic [2:0][CW-1:0]      res_r, res_nxt;
  hvt_pkg::status_t        sts_r, sts_nxt;
  logic                    ov_r;
  logic                    adv;

  assign adv        = !ov_r || out_tready;
  assign q_pop      = adv && !q_empty;
  assign out_tvalid = ov_r;
  assign out_tdata  = {{(hvt_pkg::OUT_W - 3*CW - 2){1'b0}}, sts_r,
                       res_r[2], res_r[1], res_r[0]};

  always_comb begin
    logic [AW-1:0] n;
    logic [RW-1:0] ds;
    logic          sat;
    hvt_pkg::dstg_t l;
    // capture stage: magnitudes and signs
    stg_nxt[0].vld = !q_empty;
    stg_nxt[0].wz  = (q_data[3] == '0);
    stg_nxt[0].den = q_data[3][AW-1] ? ~q_data[3] + 1'b1 : q_data[3];
    stg_nxt[0].big = '0;
    stg_nxt[0].q   = '0;
    for (int c = 0; c < 3; c++) begin
      n                 = q_data[c][AW-1] ? ~q_data[c] + 1'b1 : q_data[c];
      stg_nxt[0].rem[c] = RW'(n) << FRAC_BITS;
      stg_nxt[0].neg[c] = q_data[c][AW-1] ^ q_data[3][AW-1];
    end
    // quotient of 2^32 or more cannot be represented
    stg_nxt[1] = stg_r[0];
    for (int c = 0; c < 3; c++) begin
      stg_nxt[1].big[c] = stg_r[0].rem[c] >= {stg_r[0].den, {CW{1'b0}}};
    end
    for (int s = 2; s < NS; s++) begin
      stg_nxt[s] = stg_r[s-1];
      ds = RW'(stg_r[s-1].den) << (NS - 1 - s);
      for (int c = 0; c < 3; c++) begin
        if (stg_r[s-1].rem[c] >= ds) begin
          stg_nxt[s].rem[c]           = stg_r[s-1].rem[c] - ds;
          stg_nxt[s].q[c][NS - 1 - s] = 1'b1;
        end
      end
    end
    // saturate and sign
    l   = stg_r[NS-1];
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (!l.neg[c]) begin
        if (l.big[c] || l.q[c][CW-1]) begin
          res_nxt[c] = {1'b0, {(CW-1){1'b1}}};
          sat        = 1'b1;
        end else begin
          res_nxt[c] = l.q[c];
        end
      end else begin
        if (l.big[c] || l.q[c] > {1'b1, {(CW-1){1'b0}}}) begin
          res_nxt[c] = {1'b1, {(CW-1){1'b0}}};
          sat        = 1'b1;
        end else begin
          res_nxt[c] = ~l.q[c] + 1'b1;
        end
      end
    end
    if (l.wz) begin
      res_nxt = '0;
      sts_nxt = hvt_pkg::ST_WZERO;
    end else if (sat) begin
      sts_nxt = hvt_pkg::ST_SAT;
    end else begin
      sts_nxt = hvt_pkg::ST_OK;
    end
  end

  // only the valid bits are cleared by reset, the data just follows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) stg_r[s].vld <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      stg_r <= stg_nxt;
      ov_r  <= stg_r[NS-1].vld;
      res_r <= res_nxt;
      sts_r <= sts_nxt;
    end
  end

endmodule

### bench/homogeneous_vertex_transform_test.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_test
// Streams vertices through the 4x4 transform under several matrices and
// random idling on both sides; each output beat is checked field by field
// against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = hvt_pkg::FRAC_BITS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [31:0]      px, py, pz;
    hvt_pkg::status_t st;
  } vtx_result_t;

  class vertex_scoreboard;
    logic [hvt_pkg::REG_W-1:0] mat [hvt_pkg::NUM_REGS];
    vtx_result_t               pending [$];
    int                        errors;

    function new();
      mat = '{default: '0};
      mat[0] = 64'd1 << FB;
      mat[2] = 64'd1 << (FB + 32);
      mat[5] = 64'd1 << FB;
      mat[7] = 64'd1 << (FB + 32);
      errors = 0;
    endfunction

    function void write_reg(int idx, logic [hvt_pkg::REG_W-1:0] val);
      mat[idx] = val;
    endfunction

    function logic signed [63:0] coef(int row, int col);
      logic [63:0] r;
      r = mat[row * 2 + col / 2];
      return (col % 2) ? {{32{r[63]}}, r[63:32]} : {{32{r[31]}}, r[31:0]};
    endfunction

    // exact quotient, truncated toward zero, saturated to 32 bits
    function logic [31:0] quot(logic signed [63:0] num, logic signed [63:0] den,
                               inout bit sat);
      logic signed [127:0] n, d, q;
      n = 128'(num) <<< FB;
      d = 128'(den);
      q = n / d;
      if (q > 128'sh7FFFFFFF) begin
        sat = 1;
        return 32'h7FFFFFFF;
      end
      if (q < -128'sh80000000) begin
        sat = 1;
        return 32'h80000000;
      end
      return q[31:0];
    endfunction

    function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic signed [63:0] v [3];
      logic signed [63:0] acc [4];
      vtx_result_t r;
      bit sat;
      v[0] = $signed(x); v[1] = $signed(y); v[2] = $signed(z);
      for (int c = 0; c < 4; c++) begin
        acc[c] = coef(3, c);
        for (int k = 0; k < 3; k++) acc[c] += (coef(k, c) * v[k]) >>> FB;
      end
      sat = 0;
      if (acc[3] == 0) begin
        r.px = '0; r.py = '0; r.pz = '0; r.st = hvt_pkg::ST_WZERO;
      end else begin
        r.px = quot(acc[0], acc[3], sat);
        r.py = quot(acc[1], acc[3], sat);
        r.pz = quot(acc[2], acc[3], sat);
        r.st = sat ? hvt_pkg::ST_SAT : hvt_pkg::ST_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_beat(logic [hvt_pkg::OUT_W-1:0] d);
      vtx_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.px || d[63:32] !== e.py || d[95:64] !== e.pz
          || d[97:96] !== e.st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                   e.px, e.py, e.pz, e.st, d[31:0], d[63:32], d[95:64], d[97:96]);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [hvt_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [hvt_pkg::OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 0;
  logic [hvt_pkg::IDX_W-1:0] cfg_index = '0;
  logic [hvt_pkg::REG_W-1:0] cfg_wdata = '0;

  vertex_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  homogeneous_vertex_transform uut (.*);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_vertex(in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("homogeneous_vertex_transform_test NOT OK");
      $finish;
    end
  end

  // receiver: random wait before each beat, or a long hold-off when asked
  always begin
    int wait_n;
    wait_n = $urandom_range(0, 4);
    repeat (wait_n) @(negedge clk) out_tready <= 1'b0;
    @(negedge clk);
    while (hold_off) begin
      out_tready <= 1'b0;
      @(negedge clk);
    end
    out_tready <= 1'b1;
    do @(posedge clk); while (!hold_off && !(out_tvalid && out_tready));
  end

  // valid stays up after the beat so the next call can follow without a gap
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 4) : 0;
    repeat (g) @(negedge clk) in_tvalid <= 0;
    @(negedge clk);
    in_tvalid <= 1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_matrix_reg(int idx, logic [63:0] val);
    @(negedge clk);
    in_tvalid <= 0;
    cfg_wr_en <= 1; cfg_index <= hvt_pkg::IDX_W'(idx); cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk) cfg_wr_en <= 0;
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
      2: return 32'($signed($urandom_range(0, 400 << FB)) - (200 << FB));
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic logic [63:0] rand_reg(int mode);
    return {rand_coord(mode), rand_coord(mode)};
  endfunction

  logic [31:0] edge_vals [6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                                 32'h00010000, 32'hFFFF0000};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // identity matrix: corner values pass through
    foreach (edge_vals[i]) send_vertex(edge_vals[i], edge_vals[5 - i], edge_vals[i], 0);
    drain();
    // w forced to zero
    write_matrix_reg(7, 64'h0);
    send_vertex(32'h00010000, 32'h1, 32'h2, 0);
    drain();
    // w from z only: perspective divide, tiny w saturates
    write_matrix_reg(5, {32'h00000001, 32'h00010000});
    send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0);
    send_vertex(32'h00030000, 32'hFFFD0000, 32'h00020000, 0);
    send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 0);
    send_vertex(32'h12345678, 32'h80000000, 32'hFFFFFFFF, 0);
    drain();
    // extreme coefficients in every register
    for (int r = 0; r < hvt_pkg::NUM_REGS; r++)
      write_matrix_reg(r, (r % 2) ? 64'h80000000_7FFFFFFF : 64'h7FFFFFFF_80000000);
    foreach (edge_vals[i]) send_vertex(edge_vals[i], edge_vals[i], edge_vals[5 - i], 0);
    drain();

    // random phases with fresh matrices
    for (int ph = 0; ph < 10; ph++) begin
      int mmode;
      mmode = ph % 4;
      for (int r = 0; r < hvt_pkg::NUM_REGS; r++) write_matrix_reg(r, rand_reg(mmode));
      if (ph == 3) write_matrix_reg(7, {32'h00010000, 32'h0});
      if (ph == 5) begin
        fork
          begin
            hold_off = 1;
            repeat (150) @(posedge clk);
            hold_off = 0;
          end
          for (int i = 0; i < 80; i++)
            send_vertex(rand_coord(2), rand_coord(2), rand_coord(2), 0);
        join
      end
      for (int i = 0; i < 100; i++)
        send_vertex(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                    rand_coord($urandom_range(0, 3)), (i / 30) % 2 == 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("homogeneous_vertex_transform_test OK");
    else
      $display("homogeneous_vertex_transform_test NOT OK");
    $finish;
  end
endmodule

### homogeneous_vertex_transform.f
rtl/core/hvt_pkg.sv
rtl/core/hvt_front.sv
rtl/core/hvt_fifo.sv
rtl/core/hvt_back.sv
rtl/core/homogeneous_vertex_transform.sv
bench/homogeneous_vertex_transform_test.sv
